@@ rtl/lr_parse_driver_macros.svh @@
// Assertion helpers for lr_parse_driver
`ifndef LR_PARSE_DRIVER_MACROS_SVH
`define LR_PARSE_DRIVER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrp check failed");

// consequent must hold in the cycle after the antecedent
`define LRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrp check failed");

`endif

@@ rtl/lrp_pkg.sv @@
package lrp_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_LD_ACT  = 3'd0;
  localparam logic [2:0] OP_LD_GOTO = 3'd1;
  localparam logic [2:0] OP_LD_RULE = 3'd2;
  localparam logic [2:0] OP_LD_MAP  = 3'd3;
  localparam logic [2:0] OP_FEED    = 3'd4;

  // action kinds
  localparam logic [1:0] ACT_ERROR  = 2'd0;
  localparam logic [1:0] ACT_SHIFT  = 2'd1;
  localparam logic [1:0] ACT_REDUCE = 2'd2;
  localparam logic [1:0] ACT_ACCEPT = 2'd3;

  // result events
  localparam logic [1:0] EV_SHIFT  = 2'd0;
  localparam logic [1:0] EV_REDUCE = 2'd1;
  localparam logic [1:0] EV_ACCEPT = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  localparam logic [4:0] NOT_TERMINAL   = 5'd16;
  localparam logic [5:0] MAX_REDUCTIONS = 6'd63;

  // parameter defaults
  localparam int DEF_NUM_STATES       = 64;
  localparam int DEF_NUM_TERMINALS    = 16;
  localparam int DEF_NUM_NONTERMINALS = 16;
  localparam int DEF_NUM_RULES        = 64;
  localparam int DEF_STACK_DEPTH      = 64;

  // request to the shared index unit
  typedef struct packed {
    logic [5:0] row;
    logic [3:0] col;
    logic       use_goto;
  } idx_req_t;

endpackage

@@ rtl/lrp_if.sv @@
// Input channel
interface lrp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [5:0] state_index;
  logic [3:0] symbol_index;
  logic [1:0] action_kind;
  logic [5:0] table_target;
  logic [5:0] production_number;
  logic [3:0] rule_length;
  logic [3:0] rule_head;
  logic [7:0] character;
  logic [4:0] terminal_code;

  modport source (output valid, operation, state_index, symbol_index, action_kind,
                  table_target, production_number, rule_length, rule_head, character,
                  terminal_code, input ready);
  modport sink (input valid, operation, state_index, symbol_index, action_kind,
                table_target, production_number, rule_length, rule_head, character,
                terminal_code, output ready);
endinterface

// Result channel
interface lrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [5:0] pushed_state;
  logic [5:0] rule_used;
  logic [5:0] exposed_state;
  logic [6:0] stack_depth;
  logic       last;

  modport source (output valid, event_res, pushed_state, rule_used, exposed_state,
                  stack_depth, last, input ready);
  modport sink (input valid, event_res, pushed_state, rule_used, exposed_state,
                stack_depth, last, output ready);
endinterface

@@ rtl/lrp_idx.sv @@
// Shared table index unit: row * columns + column, for the action or goto table
module lrp_idx #(
  parameter int NUM_TERMINALS    = lrp_pkg::DEF_NUM_TERMINALS,
  parameter int NUM_NONTERMINALS = lrp_pkg::DEF_NUM_NONTERMINALS,
  parameter int IW               = 16
) (
  input  lrp_pkg::idx_req_t req,
  output logic [IW-1:0]     idx
);
  import lrp_pkg::*;

  localparam logic [IW-1:0] COLS_T = IW'(NUM_TERMINALS);
  localparam logic [IW-1:0] COLS_N = IW'(NUM_NONTERMINALS);

  logic [IW-1:0] cols;

  assign cols = req.use_goto ? COLS_N : COLS_T;
  assign idx  = IW'(IW'(req.row) * cols + IW'(req.col));
endmodule

@@ rtl/lr_parse_driver.sv @@
// Table-driven shift-reduce parser. Load items (action, goto, production,
// character map) can be taken back to back and give no result. A feed item
// gives zero or more reduce results and ends with one shift, accept or error
// result; the next feed after accept or error starts again from state 0.
// A feed reads the map and first action, then per reduction the production,
// stack, goto and action entries in turn, each from its own table, and then
// finishes; the input is not ready meanwhile, and each step past idle stalls
// while an earlier result is still untaken.
// After reset the action table and character map are swept clear, one entry a
// cycle, over max(NUM_STATES*NUM_TERMINALS, 256) entries (1024 by default),
// during which no item is accepted.
module lr_parse_driver #(
  parameter int NUM_STATES       = lrp_pkg::DEF_NUM_STATES,
  parameter int NUM_TERMINALS    = lrp_pkg::DEF_NUM_TERMINALS,
  parameter int NUM_NONTERMINALS = lrp_pkg::DEF_NUM_NONTERMINALS,
  parameter int NUM_RULES        = lrp_pkg::DEF_NUM_RULES,
  parameter int STACK_DEPTH      = lrp_pkg::DEF_STACK_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  lrp_in_if.sink    in_ch,
  lrp_out_if.source out_ch
);
  import lrp_pkg::*;
  `include "lr_parse_driver_macros.svh"

  localparam int AA    = $clog2(NUM_STATES * NUM_TERMINALS);
  localparam int GA    = $clog2(NUM_STATES * NUM_NONTERMINALS);
  localparam int IW    = (AA > GA) ? AA : GA;
  localparam int RW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int SW    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int ACT_N = NUM_STATES * NUM_TERMINALS;
  localparam int CLR_N = (ACT_N > 256) ? ACT_N : 256;
  localparam int KW    = $clog2(CLR_N) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TERM = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_RULE = 3'd3;
  localparam logic [2:0] S_EXP  = 3'd4;
  localparam logic [2:0] S_GOTO = 3'd5;

  // memories
  logic [7:0] act_mem  [ACT_N];
  logic [5:0] goto_mem [NUM_STATES * NUM_NONTERMINALS];
  logic [7:0] rule_mem [NUM_RULES];
  logic [4:0] map_mem  [256];
  logic [5:0] stk_mem  [STACK_DEPTH];

  logic [2:0]    state_r;
  logic [KW-1:0] clr_r;
  logic [CW-1:0] count_r;
  logic [5:0]    top_r;
  logic          over_r;
  logic [5:0]    k_r;
  logic [5:0]    rule_r;
  logic [3:0]    len_r;
  logic [3:0]    head_r;
  logic [5:0]    exp_r;
  logic          bottom_r;
  logic [4:0]    term_rd;
  logic [7:0]    act_rd;
  logic [7:0]    rule_rd;
  logic [5:0]    stk_rd;
  logic [5:0]    goto_rd;

  logic          out_valid_r;
  logic [1:0]    ev_r;
  logic [5:0]    push_r;
  logic [5:0]    used_r;
  logic [5:0]    expo_r;
  logic [6:0]    depth_r;
  logic          last_r;

  logic          clearing;
  logic          out_free;
  logic          in_acc;
  idx_req_t      ireq;
  logic [IW-1:0] idx;

  assign clearing = (clr_r < KW'(CLR_N));
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !clearing;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // shared index unit: operands chosen by the sequencer step
  always_comb begin
    ireq = '0;
    case (state_r)
      S_IDLE: begin
        ireq.row      = in_ch.state_index;
        ireq.col      = in_ch.symbol_index;
        ireq.use_goto = (in_ch.operation == OP_LD_GOTO);
      end
      S_TERM: begin
        ireq.row = top_r;
        ireq.col = term_rd[3:0];
      end
      S_EXP: begin
        ireq.row      = bottom_r ? 6'd0 : stk_rd;
        ireq.col      = head_r;
        ireq.use_goto = 1'b1;
      end
      S_GOTO: begin
        ireq.row = goto_rd;
        ireq.col = term_rd[3:0];
      end
      default: ireq = '0;
    endcase
  end

  lrp_idx #(
    .NUM_TERMINALS    (NUM_TERMINALS),
    .NUM_NONTERMINALS (NUM_NONTERMINALS),
    .IW               (IW)
  ) u_idx (
    .req (ireq),
    .idx (idx)
  );

  // decoded fields for the current step
  logic [1:0]    kind;
  logic [5:0]    target;
  logic [3:0]    rlen;
  logic [3:0]    rhead;
  logic [5:0]    exposed;
  logic [CW-1:0] base;
  logic [CW-1:0] pos;

  assign kind    = act_rd[7:6];
  assign target  = act_rd[5:0];
  assign rlen    = rule_rd[3:0];
  assign rhead   = rule_rd[7:4];
  assign exposed = bottom_r ? 6'd0 : stk_rd;
  assign base    = count_r - CW'(len_r);
  assign pos     = count_r - CW'(1) - CW'(rlen);

  // action table and character map: load writes and reset sweep
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_r < KW'(ACT_N)) act_mem[AA'(clr_r)] <= '0;
      if (clr_r < KW'(256))   map_mem[clr_r[7:0]] <= NOT_TERMINAL;
    end else if (in_acc) begin
      if (in_ch.operation == OP_LD_ACT && {26'd0, in_ch.state_index} < NUM_STATES &&
          {28'd0, in_ch.symbol_index} < NUM_TERMINALS)
        act_mem[AA'(idx)] <= {in_ch.action_kind, in_ch.table_target};
      if (in_ch.operation == OP_LD_MAP)
        map_mem[in_ch.character] <= in_ch.terminal_code;
    end
  end

  // goto table and production table writes
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.operation == OP_LD_GOTO &&
        {26'd0, in_ch.state_index} < NUM_STATES &&
        {28'd0, in_ch.symbol_index} < NUM_NONTERMINALS)
      goto_mem[GA'(idx)] <= in_ch.table_target;
    if (in_acc && in_ch.operation == OP_LD_RULE &&
        {26'd0, in_ch.production_number} < NUM_RULES)
      rule_mem[RW'(in_ch.production_number)] <= {in_ch.rule_head, in_ch.rule_length};
  end

  // registered table reads
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.operation == OP_FEED) term_rd <= map_mem[in_ch.character];
    if (out_free) begin
      if (state_r == S_TERM || state_r == S_GOTO) act_rd <= act_mem[AA'(idx)];
      if (state_r == S_ACT)  rule_rd <= rule_mem[RW'(target)];
      if (state_r == S_RULE) stk_rd  <= stk_mem[SW'(pos)];
      if (state_r == S_EXP)  goto_rd <= goto_mem[GA'(idx)];
    end
  end

  // state stack pushes
  always_ff @(posedge clk) begin
    if (out_free && state_r == S_ACT && kind == ACT_SHIFT)
      stk_mem[SW'(count_r)] <= target;
    else if (out_free && state_r == S_GOTO)
      stk_mem[SW'(base)] <= goto_rd;
  end

  // sequencer
  logic          emit;
  logic [1:0]    emit_ev;
  logic [5:0]    emit_push;
  logic          emit_last;
  logic [2:0]    state_nxt;
  logic [CW-1:0] count_nxt;
  logic [5:0]    top_nxt;
  logic          over_nxt;

  always_comb begin
    emit      = 1'b0;
    emit_ev   = EV_ERROR;
    emit_push = '0;
    emit_last = 1'b1;
    state_nxt = state_r;
    count_nxt = count_r;
    top_nxt   = top_r;
    over_nxt  = over_r;
    if (state_r == S_IDLE) begin
      if (in_acc && in_ch.operation == OP_FEED) begin
        state_nxt = S_TERM;
        if (over_r) begin
          count_nxt = CW'(1);
          top_nxt   = '0;
          over_nxt  = 1'b0;
        end
      end
    end else if (out_free) begin
      unique case (state_r)
        S_TERM: begin
          if (term_rd >= NOT_TERMINAL || {27'd0, term_rd} >= NUM_TERMINALS) begin
            emit = 1'b1;
          end else begin
            state_nxt = S_ACT;
          end
        end
        S_ACT: begin
          unique case (kind)
            ACT_SHIFT: begin
              emit = 1'b1;
              if ({26'd0, target} < NUM_STATES && count_r < CW'(STACK_DEPTH)) begin
                emit_ev   = EV_SHIFT;
                emit_push = target;
                count_nxt = count_r + CW'(1);
                top_nxt   = target;
              end
            end
            ACT_ACCEPT: begin
              emit    = 1'b1;
              emit_ev = EV_ACCEPT;
            end
            ACT_REDUCE: begin
              if (k_r >= MAX_REDUCTIONS || {26'd0, target} >= NUM_RULES) emit = 1'b1;
              else state_nxt = S_RULE;
            end
            default: emit = 1'b1;
          endcase
        end
        S_RULE: begin
          if ({28'd0, rhead} >= NUM_NONTERMINALS || {28'd0, rlen} >= 32'(count_r))
            emit = 1'b1;
          else state_nxt = S_EXP;
        end
        S_EXP: begin
          if ({26'd0, exposed} >= NUM_STATES) emit = 1'b1;
          else state_nxt = S_GOTO;
        end
        S_GOTO: begin
          emit = 1'b1;
          if ({26'd0, goto_rd} < NUM_STATES && base < CW'(STACK_DEPTH)) begin
            emit_ev   = EV_REDUCE;
            emit_push = goto_rd;
            emit_last = 1'b0;
            count_nxt = base + CW'(1);
            top_nxt   = goto_rd;
            state_nxt = S_ACT;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
      if (emit && emit_last) begin
        state_nxt = S_IDLE;
        if (emit_ev != EV_SHIFT) over_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= '0;
      count_r     <= CW'(1);
      top_r       <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      top_r   <= top_nxt;
      over_r  <= over_nxt;
      if (clearing) clr_r <= clr_r + KW'(1);
      if (in_acc) k_r <= '0;
      else if (emit && !emit_last) k_r <= k_r + 6'd1;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // per-step operands and output payload
  always_ff @(posedge clk) begin
    if (out_free && state_r == S_ACT) rule_r <= target;
    if (out_free && state_r == S_RULE) begin
      len_r    <= rlen;
      head_r   <= rhead;
      bottom_r <= (pos == '0);
    end
    if (out_free && state_r == S_EXP) exp_r <= exposed;
    if (emit) begin
      ev_r    <= emit_ev;
      push_r  <= emit_push;
      used_r  <= (emit_ev == EV_REDUCE) ? rule_r : 6'd0;
      expo_r  <= (emit_ev == EV_REDUCE) ? exp_r : 6'd0;
      depth_r <= 7'(count_nxt);
      last_r  <= emit_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = ev_r;
  assign out_ch.pushed_state  = push_r;
  assign out_ch.rule_used     = used_r;
  assign out_ch.exposed_state = expo_r;
  assign out_ch.stack_depth   = depth_r;
  assign out_ch.last          = last_r;

  // checks
  `LRP_ASSERT_SAME(a_no_take_while_clear, clearing, !in_ch.ready)
  `LRP_ASSERT_SAME(a_count_range, 1'b1, count_r != '0 && count_r <= CW'(STACK_DEPTH))
  `LRP_ASSERT_NEXT(a_feed_starts, in_acc && in_ch.operation == OP_FEED, state_r == S_TERM)
  `LRP_ASSERT_SAME(a_reduce_limit, emit && emit_ev == EV_REDUCE, k_r < MAX_REDUCTIONS)
endmodule

@@ tb/testbench.sv @@
module testbench;
  import lrp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lrp_in_if  in_ch();
  lrp_out_if out_ch();

  lr_parse_driver dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // one input item
  typedef struct {
    logic [2:0] op;
    logic [5:0] st;
    logic [3:0] sym;
    logic [1:0] kind;
    logic [5:0] tgt;
    logic [5:0] prod;
    logic [3:0] len;
    logic [3:0] head;
    logic [7:0] ch;
    logic [4:0] code;
  } item_t;

  // one parser event
  typedef struct packed {
    logic [1:0] ev;
    logic [5:0] pushed;
    logic [5:0] rule;
    logic [5:0] exposed;
    logic [6:0] depth;
    logic       last;
  } parse_event_t;

  item_t        item_queue[$];
  parse_event_t expected_events[$];

  // parser tables as the block should hold them
  bit [1:0] act_kind[64][16];
  bit [5:0] act_tgt[64][16];
  bit [5:0] goto_tab[64][16];
  bit       goto_set[64][16];
  bit [3:0] rule_len[64];
  bit [3:0] rule_head[64];
  bit       rule_set[64];
  bit [4:0] term_of[256];
  bit [5:0] pstack[64];
  int       pdepth;
  bit       pdone;

  int mismatches = 0;
  int n_events = 0;
  int n_feeds = 0;
  int n_reductions = 0;
  int n_errors_seen = 0;
  int cycle = 0;
  bit finished = 0;

  function automatic void apply_load(item_t it);
    case (it.op)
      OP_LD_ACT: begin
        act_kind[it.st][it.sym] = it.kind;
        act_tgt[it.st][it.sym] = it.tgt;
      end
      OP_LD_GOTO: begin
        goto_tab[it.st][it.sym] = it.tgt;
        goto_set[it.st][it.sym] = 1'b1;
      end
      OP_LD_RULE: begin
        rule_len[it.prod] = it.len;
        rule_head[it.prod] = it.head;
        rule_set[it.prod] = 1'b1;
      end
      OP_LD_MAP: term_of[it.ch] = it.code;
      default: ;
    endcase
  endfunction

  function automatic parse_event_t mk_ev(logic [1:0] ev, logic [5:0] p, logic [5:0] r,
                                         logic [5:0] x, int d, logic l);
    parse_event_t e;
    e.ev = ev; e.pushed = p; e.rule = r; e.exposed = x; e.depth = d[6:0]; e.last = l;
    return e;
  endfunction

  // Walks one feed. Without commit it only reports an unwritten goto or
  // production entry that would be read (miss: 1 goto, 2 production).
  function automatic void parse_char(input logic [7:0] ch, input bit commit,
                                     output int miss, output int ma, output int mb);
    bit [5:0] s[64];
    int n;
    int k;
    bit over;
    bit fin;
    bit [4:0] t;
    bit [5:0] top, tg, x, nx;
    bit [3:0] ln, hd;
    parse_event_t evq[$];
    miss = 0; ma = 0; mb = 0;
    s = pstack; n = pdepth; over = pdone; k = 0; fin = 0;
    if (over) begin
      foreach (s[i]) s[i] = '0;
      n = 1; over = 0;
    end
    t = term_of[ch];
    if (t >= NOT_TERMINAL) begin
      evq.insert(evq.size(), mk_ev(EV_ERROR, 0, 0, 0, n, 1)); over = 1; fin = 1;
    end
    while (!fin) begin
      top = s[n-1];
      tg = act_tgt[top][t[3:0]];
      case (act_kind[top][t[3:0]])
        ACT_SHIFT: begin
          if (n >= 64) begin
            evq.insert(evq.size(), mk_ev(EV_ERROR, 0, 0, 0, n, 1)); over = 1;
          end else begin
            s[n] = tg; n++;
            evq.insert(evq.size(), mk_ev(EV_SHIFT, tg, 0, 0, n, 1));
          end
          fin = 1;
        end
        ACT_ACCEPT: begin
          evq.insert(evq.size(), mk_ev(EV_ACCEPT, 0, 0, 0, n, 1)); over = 1; fin = 1;
        end
        ACT_REDUCE: begin
          if (k >= MAX_REDUCTIONS) begin
            evq.insert(evq.size(), mk_ev(EV_ERROR, 0, 0, 0, n, 1)); over = 1; fin = 1;
          end else if (!rule_set[tg]) begin
            miss = 2; ma = tg; return;
          end else begin
            ln = rule_len[tg]; hd = rule_head[tg];
            if (ln >= n) begin
              evq.insert(evq.size(), mk_ev(EV_ERROR, 0, 0, 0, n, 1)); over = 1; fin = 1;
            end else begin
              x = s[n-1-ln];
              if (!goto_set[x][hd]) begin
                miss = 1; ma = x; mb = hd; return;
              end
              nx = goto_tab[x][hd];
              if (n - ln >= 64) begin
                evq.insert(evq.size(), mk_ev(EV_ERROR, 0, 0, 0, n, 1)); over = 1; fin = 1;
              end else begin
                n = n - ln; s[n] = nx; n++; k++;
                evq.insert(evq.size(), mk_ev(EV_REDUCE, nx, tg, x, n, 0));
              end
            end
          end
        end
        default: begin
          evq.insert(evq.size(), mk_ev(EV_ERROR, 0, 0, 0, n, 1)); over = 1; fin = 1;
        end
      endcase
    end
    if (commit) begin
      pstack = s; pdepth = n; pdone = over;
      foreach (evq[i]) expected_events.insert(expected_events.size(), evq[i]);
      n_reductions += k;
    end
  endfunction

  function automatic item_t blank_item(logic [2:0] op);
    item_t it;
    it = '{op: op, st: 0, sym: 0, kind: 0, tgt: 0, prod: 0, len: 0, head: 0, ch: 0,
           code: 0};
    return it;
  endfunction

  function automatic void queue_load(item_t it);
    apply_load(it);
    item_queue.insert(item_queue.size(), it);
  endfunction

  function automatic void load_act(int st, int sym, logic [1:0] kind, int tgt);
    item_t it;
    it = blank_item(OP_LD_ACT);
    it.st = 6'(st); it.sym = 4'(sym); it.kind = kind; it.tgt = 6'(tgt);
    queue_load(it);
  endfunction

  function automatic void load_goto(int st, int sym, int tgt);
    item_t it;
    it = blank_item(OP_LD_GOTO);
    it.st = 6'(st); it.sym = 4'(sym); it.tgt = 6'(tgt);
    queue_load(it);
  endfunction

  function automatic void load_rule(int p, int len, int head);
    item_t it;
    it = blank_item(OP_LD_RULE);
    it.prod = 6'(p); it.len = 4'(len); it.head = 4'(head);
    queue_load(it);
  endfunction

  function automatic void load_map(int ch, int code);
    item_t it;
    it = blank_item(OP_LD_MAP);
    it.ch = 8'(ch); it.code = 5'(code);
    queue_load(it);
  endfunction

  // fill in any entry the feed would read unwritten, then predict it
  function automatic void queue_feed(logic [7:0] ch);
    item_t it;
    int miss, ma, mb;
    forever begin
      parse_char(ch, 0, miss, ma, mb);
      if (miss == 0) break;
      if (miss == 1)
        load_goto(ma, mb, ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7));
      else
        load_rule(ma, $urandom_range(3), $urandom_range(3));
    end
    parse_char(ch, 1, miss, ma, mb);
    it = blank_item(OP_FEED);
    it.ch = ch;
    it.st = 6'($urandom); it.sym = 4'($urandom); it.kind = 2'($urandom);
    it.tgt = 6'($urandom); it.code = 5'($urandom);
    item_queue.insert(item_queue.size(), it);
    n_feeds++;
  endfunction

  // stimulus
  initial begin
    item_t it;
    logic [7:0] pool[8];
    int r;
    foreach (act_kind[i, j]) begin
      act_kind[i][j] = ACT_ERROR; act_tgt[i][j] = 0; goto_set[i][j] = 0;
    end
    foreach (rule_set[i]) rule_set[i] = 0;
    foreach (term_of[i]) term_of[i] = NOT_TERMINAL;
    foreach (pstack[i]) pstack[i] = 0;
    pdepth = 1; pdone = 0;

    // directed: tiny grammar, restart, endless reduction, underflow, overflow
    load_map("a", 0); load_map("+", 1); load_map("#", 2); load_map(8'hFE, 14);
    load_map(8'hFF, 31);
    queue_feed(8'h00);
    queue_feed(8'hFF);
    load_act(0, 0, ACT_SHIFT, 1);
    load_act(1, 2, ACT_REDUCE, 0);
    load_rule(0, 1, 0);
    load_goto(0, 0, 2);
    load_act(2, 2, ACT_ACCEPT, 0);
    queue_feed("a"); queue_feed("#");
    queue_feed("#");
    load_act(1, 1, ACT_REDUCE, 1);
    load_rule(1, 1, 1);
    load_goto(0, 1, 1);
    queue_feed("a"); queue_feed("+");
    load_act(0, 14, ACT_REDUCE, 2);
    load_rule(2, 5, 3);
    queue_feed(8'hFE);
    load_act(0, 14, ACT_SHIFT, 5);
    load_act(5, 14, ACT_SHIFT, 5);
    for (int i = 0; i < 64; i++) queue_feed(8'hFE);
    load_act(63, 15, ACT_ACCEPT, 63);
    load_goto(63, 15, 63);
    load_rule(63, 15, 15);
    it = blank_item(3'd7); it.ch = 8'hFF; it.code = 5'h1F; it.st = 6'h3F;
    item_queue.insert(item_queue.size(), it);

    // random: a small grammar region with occasional full-range noise
    foreach (pool[i]) begin
      pool[i] = 8'($urandom);
      load_map(pool[i], i % 4);
    end
    while (item_queue.size() < 280) begin
      r = $urandom_range(99);
      if (r < 55) begin
        queue_feed(($urandom_range(19) == 0) ? 8'($urandom) : pool[$urandom_range(7)]);
      end else if (r < 70) begin
        r = $urandom_range(9);
        load_act($urandom_range(7), $urandom_range(3),
                 (r < 4) ? ACT_REDUCE : (r < 7) ? ACT_SHIFT : (r < 8) ? ACT_ACCEPT : ACT_ERROR,
                 $urandom_range(7));
      end else if (r < 78) begin
        load_goto($urandom_range(7), $urandom_range(3), $urandom_range(7));
      end else if (r < 85) begin
        load_rule($urandom_range(7), $urandom_range(3), $urandom_range(3));
      end else if (r < 90) begin
        load_map(pool[$urandom_range(7)],
                 ($urandom_range(4) == 0) ? $urandom_range(16, 31) : $urandom_range(3));
      end else if (r < 96) begin
        it = blank_item(3'($urandom_range(3)));
        it.st = 6'($urandom); it.sym = 4'($urandom); it.kind = 2'($urandom);
        it.tgt = 6'($urandom); it.prod = 6'($urandom); it.len = 4'($urandom);
        it.head = 4'($urandom); it.code = 5'($urandom);
        it.ch = (it.op == OP_LD_MAP) ? 8'($urandom_range(128, 255)) : 8'($urandom);
        queue_load(it);
      end else begin
        it = blank_item(3'($urandom_range(5, 7)));
        it.st = 6'($urandom); it.sym = 4'($urandom); it.kind = 2'($urandom);
        it.tgt = 6'($urandom); it.prod = 6'($urandom); it.len = 4'($urandom);
        it.head = 4'($urandom); it.ch = 8'($urandom); it.code = 5'($urandom);
        item_queue.insert(item_queue.size(), it);
      end
    end
  end

  // reset and cycle count
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic bit idle_now();
    return (cycle < 1300 || cycle > 1700) && ($urandom_range(99) < 17);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (item_queue.size() > 0 && !idle_now()) begin
        item_t it;
        it = item_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= it.op;
        in_ch.state_index <= it.st;
        in_ch.symbol_index <= it.sym;
        in_ch.action_kind <= it.kind;
        in_ch.table_target <= it.tgt;
        in_ch.production_number <= it.prod;
        in_ch.rule_length <= it.len;
        in_ch.rule_head <= it.head;
        in_ch.character <= it.ch;
        in_ch.terminal_code <= it.code;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0; in_ch.state_index = '0; in_ch.symbol_index = '0;
    in_ch.action_kind = '0; in_ch.table_target = '0; in_ch.production_number = '0;
    in_ch.rule_length = '0; in_ch.rule_head = '0; in_ch.character = '0;
    in_ch.terminal_code = '0;
    out_ch.ready = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
      if (out_ch.valid && out_ch.ready) begin
        parse_event_t got, want;
        got = mk_ev(out_ch.event_res, out_ch.pushed_state, out_ch.rule_used,
                    out_ch.exposed_state, int'(out_ch.stack_depth), out_ch.last);
        n_events++;
        if (got.ev == EV_ERROR) n_errors_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected ev=%0d p=%0d r=%0d x=%0d d=%0d l=%0d",
                     got.ev, got.pushed, got.rule, got.exposed, got.depth, got.last);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb: event %0d expected ev=%0d p=%0d r=%0d x=%0d d=%0d l=%0d",
                       n_events, want.ev, want.pushed, want.rule, want.exposed,
                       want.depth, want.last);
              $display("tb:   got ev=%0d p=%0d r=%0d x=%0d d=%0d l=%0d",
                       got.ev, got.pushed, got.rule, got.exposed, got.depth, got.last);
            end
          end
        end
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    while (item_queue.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    finished = 1;
    mismatches += expected_events.size();
    $display("tb: %0d feeds predicted, %0d events checked (%0d reductions, %0d errors)",
             n_feeds, n_events, n_reductions, n_errors_seen);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    if (!finished) begin
      $display("tb: failure");
      $finish;
    end
  end
endmodule
